// ===== rtl/icfm_pkg.sv =====
// shared widths and constants of the input capture frequency meter
`default_nettype none
package icfm_pkg;
	localparam int unsigned CAP_W   = 16;
	localparam int unsigned STAMP_W = 32;
	localparam int unsigned FREQ_W  = 32;
	localparam logic [FREQ_W-1:0] CLK_HZ_RESET = 32'd2000000;

	// event kinds
	localparam logic FUNC_OVERFLOW = 1'b0;
	localparam logic FUNC_CAPTURE  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/icfm_if.sv =====
// valid/ready channel interfaces of the input capture frequency meter
`default_nettype none
interface icfm_sample_if import icfm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             func;
	logic [CAP_W-1:0] capture_value;

	modport source (output valid, output func, output capture_value, input ready);
	modport sink (input valid, input func, input capture_value, output ready);
endinterface

interface icfm_result_if import icfm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] frequency_hz;

	modport source (output valid, output frequency_hz, input ready);
	modport sink (input valid, input frequency_hz, output ready);
endinterface

interface icfm_cfg_if import icfm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FREQ_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/icfm_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module icfm_div import icfm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] num,
	input  wire logic [FREQ_W-1:0] den,
	output logic                   done,
	output logic [FREQ_W-1:0]      quot
);
	localparam int unsigned CNT_W = $clog2(FREQ_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FREQ_W:0]   rem_q;
	logic [FREQ_W-1:0] quot_q;
	logic [FREQ_W-1:0] den_q;

	logic [FREQ_W:0] rem_shift;
	logic [FREQ_W:0] rem_diff;
	logic            fits;

	// shift in the next numerator bit and trial subtract
	assign rem_shift = {rem_q[FREQ_W-1:0], quot_q[FREQ_W-1]};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign fits      = rem_shift >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(FREQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= num;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_diff : rem_shift;
			quot_q <= {quot_q[FREQ_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== rtl/input_capture_frequency_meter.sv =====
// Reciprocal frequency meter. An overflow event or a capture that produces no
// result is taken while the block stays idle. A capture that follows an
// earlier one with a nonzero tick difference starts the radix-2 divider; the
// block takes no new request while it accepts the capture, runs 32 divider
// steps and loads the result register, waiting while that register is full.
// The user must write the timer clock register through cfg only while the
// block is idle; the block itself does not enforce it. It resets to 2 MHz.
`default_nettype none
module input_capture_frequency_meter import icfm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	icfm_sample_if.sink   sample,
	icfm_result_if.source result,
	icfm_cfg_if.sink      cfg
);
	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_WAIT} state_t;

	state_t            state_q;
	logic [FREQ_W-1:0] clk_hz_q;
	logic [CAP_W-1:0]  ovf_q;
	logic [STAMP_W-1:0] last_q;
	logic              have_prev_q;
	logic              res_valid_q;
	logic [FREQ_W-1:0] res_q;

	logic               accept;
	logic [STAMP_W-1:0] stamp;
	logic [STAMP_W-1:0] delta;
	logic               div_start;
	logic               div_done;
	logic [FREQ_W-1:0]  div_quot;
	logic               slot_free;

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign stamp        = {ovf_q, sample.capture_value};
	assign delta        = stamp - last_q;
	assign div_start    = accept && (sample.func == FUNC_CAPTURE) && have_prev_q
		&& (delta != '0);
	assign slot_free    = !res_valid_q || result.ready;

	assign cfg.ready = 1'b1;

	icfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (clk_hz_q),
		.den    (delta),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clk_hz_q    <= CLK_HZ_RESET;
			ovf_q       <= '0;
			last_q      <= '0;
			have_prev_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				clk_hz_q <= cfg.data;
			end
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sample.func == FUNC_OVERFLOW) begin
							ovf_q <= ovf_q + 1'b1;
						end else begin
							last_q      <= stamp;
							have_prev_q <= 1'b1;
							if (div_start) begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (slot_free) begin
							res_q       <= div_quot;
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					// quotient stays in the divider until the result slot drains
					if (slot_free) begin
						res_q       <= div_quot;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid        = res_valid_q;
	assign result.frequency_hz = res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> state_q == ST_IDLE)
		else $error("divider started while busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_div_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV)
		else $error("divide state not entered after start");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && slot_free) |=> res_valid_q && state_q == ST_IDLE)
		else $error("pending quotient not loaded");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the input capture frequency meter: random event streams checked against a predictor
`timescale 1ns / 100ps

module tb_top;
	import icfm_pkg::*;

	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic             func;
		logic [CAP_W-1:0] cap;
	} meter_event_t;

	logic clk = 1'b0;
	logic arst_n;

	icfm_sample_if sample_ch ();
	icfm_result_if result_ch ();
	icfm_cfg_if    cfg_ch ();

	input_capture_frequency_meter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [FREQ_W-1:0]  clk_hz = CLK_HZ_RESET;
	logic [15:0]        ovf_cnt = '0;
	logic [STAMP_W-1:0] last_stamp = '0;
	logic               have_stamp = 1'b0;
	logic [FREQ_W-1:0]  expected_freq[$];

	// stimulus state
	meter_event_t       pend_events[$];
	int                 queued = 0;
	logic [15:0]        gen_ovf = '0;
	logic [CAP_W-1:0]   gen_low = '0;
	int                 tx_idle_pct = 0;
	int                 rx_idle_pct = 0;
	int                 tx_gap = 0;
	int                 rx_stall = 0;
	int                 errors = 0;
	int                 cycles = 0;

	task automatic report_mismatch(input string what, input logic [FREQ_W-1:0] got,
			input logic [FREQ_W-1:0] want);
		errors++;
		if (errors <= 50)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic void predict_event(input logic func, input logic [CAP_W-1:0] cap);
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] delta;
		if (func == FUNC_OVERFLOW) begin
			ovf_cnt = ovf_cnt + 16'd1;
			return;
		end
		stamp = {ovf_cnt, cap};
		if (have_stamp) begin
			delta = stamp - last_stamp;
			// equal stamps give no result
			if (delta != '0)
				expected_freq.push_back(clk_hz / delta);
		end else begin
			have_stamp = 1'b1;
		end
		last_stamp = stamp;
	endfunction

	function automatic void push_event(input logic func, input logic [CAP_W-1:0] cap);
		meter_event_t ev;
		ev.func = func;
		ev.cap = cap;
		pend_events.push_back(ev);
		queued++;
		if (func == FUNC_OVERFLOW)
			gen_ovf++;
		else
			gen_low = cap;
	endfunction

	// let the timer run span ticks from the last capture, one overflow per rollover
	task automatic push_measure(input longint unsigned span);
		longint unsigned start_pos;
		longint unsigned stop_pos;
		longint unsigned rolls;
		start_pos = 64'({gen_ovf, gen_low});
		stop_pos = start_pos + span;
		rolls = (stop_pos >> 16) - (start_pos >> 16);
		repeat (rolls) push_event(FUNC_OVERFLOW, 16'($urandom));
		push_event(FUNC_CAPTURE, stop_pos[15:0]);
	endtask

	task automatic push_random(input int count);
		int stop_at;
		longint unsigned span;
		stop_at = queued + count;
		while (queued < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				push_event(1'($urandom), 16'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0: span = 0;
					1, 2, 3: span = 64'($urandom_range(1, 200));
					4, 5, 6: span = 64'($urandom_range(200, 70000));
					7: span = 64'($urandom_range(70000, 400000));
					default: span = 64'($urandom_range(1, 65535));
				endcase
				push_measure(span);
			end
		end
	endtask

	// everything sent and answered, then let the divider settle
	task automatic drain();
		do @(negedge clk);
		while (pend_events.size() != 0 || sample_ch.valid || expected_freq.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_clock_hz(input logic [FREQ_W-1:0] hz);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= hz;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		clk_hz = hz;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.func <= FUNC_OVERFLOW;
			sample_ch.capture_value <= '0;
			tx_gap = 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				predict_event(sample_ch.func, sample_ch.capture_value);
			if (!sample_ch.valid || sample_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					sample_ch.valid <= 1'b0;
				end else if (pend_events.size() != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
					tx_gap = $urandom_range(0, 4);
					sample_ch.valid <= 1'b0;
				end else if (pend_events.size() != 0) begin
					meter_event_t ev;
					ev = pend_events.pop_front();
					sample_ch.valid <= 1'b1;
					sample_ch.func <= ev.func;
					sample_ch.capture_value <= ev.cap;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_freq.size() == 0)
					report_mismatch("unexpected result", result_ch.frequency_hz, '0);
				else begin
					logic [FREQ_W-1:0] want;
					want = expected_freq.pop_front();
					if (result_ch.frequency_hz !== want)
						report_mismatch("frequency_hz", result_ch.frequency_hz, want);
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				result_ch.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				rx_stall = $urandom_range(0, 4);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset clock rate: first capture, zero delta, tiny, wrapped-back and ignored values
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		push_event(FUNC_OVERFLOW, 16'hFFFF);
		push_event(FUNC_CAPTURE, 16'h0000);
		push_event(FUNC_CAPTURE, 16'h0000);
		push_event(FUNC_CAPTURE, 16'h0001);
		push_event(FUNC_CAPTURE, 16'hFFFF);
		push_event(FUNC_OVERFLOW, 16'h5555);
		push_event(FUNC_CAPTURE, 16'h0000);
		push_event(FUNC_CAPTURE, 16'h7FFF);
		push_event(FUNC_CAPTURE, 16'h0003);
		push_event(FUNC_CAPTURE, 16'h5555);
		push_event(FUNC_OVERFLOW, 16'hAAAA);
		push_event(FUNC_CAPTURE, 16'hAAAA);
		drain();

		write_clock_hz(32'hFFFF_FFFF);
		push_event(FUNC_CAPTURE, 16'hAAAB);
		push_event(FUNC_CAPTURE, 16'hAAAD);
		drain();

		// zero rate still gives a result when delta is nonzero
		write_clock_hz(32'd0);
		push_event(FUNC_CAPTURE, 16'hAAB2);
		push_event(FUNC_CAPTURE, 16'hAAB2);
		drain();

		write_clock_hz(32'd1);
		push_event(FUNC_CAPTURE, 16'hAAB3);
		push_event(FUNC_CAPTURE, 16'hAAB5);
		drain();

		write_clock_hz(32'd16_000_000);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		push_random(400);
		drain();

		write_clock_hz($urandom);
		tx_idle_pct = 30;
		rx_idle_pct = 30;
		push_random(400);
		drain();

		// a period over many rollovers gives a quotient near one
		write_clock_hz(32'd2_000_000);
		tx_idle_pct = 5;
		rx_idle_pct = 5;
		push_random(20);
		push_measure(64'd1_000_000 + 64'($urandom_range(1, 5000)));
		push_random(20);
		drain();

		write_clock_hz(32'd16_000_000);
		tx_idle_pct = 10;
		rx_idle_pct = 40;
		push_random(400);
		drain();

		write_clock_hz($urandom_range(1, 1000));
		tx_idle_pct = 40;
		rx_idle_pct = 10;
		push_random(300);
		drain();

		write_clock_hz(32'd2_000_000);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		push_random(400);
		drain();

		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end
endmodule
